@@ sv/sbda_pkg.sv @@
// Shared constants and types for the signed binary to decimal ASCII converter.
package sbda_pkg;

    // Width of the signed input number
    localparam int NUMBER_WIDTH = 32;
    // Input stream data width: number padded to whole bytes
    localparam int IN_DATA_W    = ((NUMBER_WIDTH + 7) / 8) * 8;
    // Decimal digits needed for the largest magnitude, 2^(NUMBER_WIDTH-1)
    localparam int NUM_DIGITS   = ((NUMBER_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int BCD_W        = NUM_DIGITS * 4;
    localparam int BIT_CNT_W    = $clog2(NUMBER_WIDTH + 1);
    localparam int DIG_CNT_W    = $clog2(NUM_DIGITS + 1);

    // Output character field and stream data width
    localparam int CHAR_W       = 6;
    localparam int OUT_DATA_W   = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef logic [NUMBER_WIDTH-1:0] mag_t;
    typedef logic [BCD_W-1:0]        bcd_t;

    // Handshake between sequencer and conversion unit
    typedef struct packed {
        logic start;
    } sbda_conv_req_t;

    typedef struct packed {
        logic done;
    } sbda_conv_rsp_t;

endpackage

@@ sv/sbda_conv.sv @@
// Shift-and-add-3 binary to BCD unit, one magnitude bit per cycle.
module sbda_conv
    import sbda_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  sbda_conv_req_t req,
    input  mag_t           mag,
    output sbda_conv_rsp_t rsp,
    output bcd_t           bcd
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    mag_t                 mag_reg, mag_next;
    bcd_t                 bcd_reg, bcd_next;
    bcd_t                 bcd_adj;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (bcd_reg[d*4 +: 4] >= 4'd5)
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4] + 4'd3;
            else
                bcd_adj[d*4 +: 4] = bcd_reg[d*4 +: 4];
        end
    end

    // Load on start, then shift one bit into the BCD word each cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = BIT_CNT_W'(NUMBER_WIDTH);
            mag_next  = mag;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[NUMBER_WIDTH-1]};
            mag_next = {mag_reg[NUMBER_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - BIT_CNT_W'(1);
            if (cnt_reg == BIT_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign rsp.done = done_reg;
    assign bcd      = bcd_reg;

endmodule

@@ sv/signed_binary_to_decimal_ascii_top.sv @@
// Top level: signed number in, decimal ASCII characters out with a last mark.
// Steps: the magnitude is shifted bit by bit into a BCD word, the word is handed over,
// leading zero digits are dropped, then the sign (if negative) and the digits pass
// through the output register. A new number is accepted only once the last character
// of the previous one has entered the output register; output stalls hold the sequence.
// Reset: asynchronous, active low; returns the sequencer to idle, empties the output register.
module signed_binary_to_decimal_ascii_top
    import sbda_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [NUMBER_WIDTH-1:0] number
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] char_code, rest zero
    output logic                  m_axis_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_TRIM  = 3'd2;
    localparam logic [2:0] ST_SIGN  = 3'd3;
    localparam logic [2:0] ST_DIGIT = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic                 neg_reg, neg_next;
    bcd_t                 digits_reg, digits_next;
    logic [DIG_CNT_W-1:0] left_reg, left_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]    out_char_reg, out_char_next;
    logic                 out_last_reg, out_last_next;

    sbda_conv_req_t       conv_req;
    sbda_conv_rsp_t       conv_rsp;
    bcd_t                 conv_bcd;
    mag_t                 raw;
    mag_t                 mag;
    logic                 in_fire;
    logic                 out_free;
    logic [3:0]           top_digit;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign top_digit     = digits_reg[BCD_W-1 -: 4];

    // Take the magnitude, keeping the most negative value as 2^(W-1)
    assign raw = s_axis_tdata[NUMBER_WIDTH-1:0];
    assign mag = raw[NUMBER_WIDTH-1] ? (~raw + mag_t'(1)) : raw;

    assign conv_req.start = in_fire;

    sbda_conv u_conv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .mag   (mag),
        .rsp   (conv_rsp),
        .bcd   (conv_bcd)
    );

    // Sequence: convert, drop leading zeros, send sign and digits
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        digits_next    = digits_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    neg_next   = raw[NUMBER_WIDTH-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_rsp.done)
                begin
                    digits_next = conv_bcd;
                    left_next   = DIG_CNT_W'(NUM_DIGITS);
                    state_next  = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (top_digit == 4'd0 && left_reg > DIG_CNT_W'(1))
                begin
                    digits_next = {digits_reg[BCD_W-5:0], 4'd0};
                    left_next   = left_reg - DIG_CNT_W'(1);
                end
                else if (neg_reg)
                    state_next = ST_SIGN;
                else
                    state_next = ST_DIGIT;
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO + CHAR_W'(top_digit);
                    out_last_next  = (left_reg == DIG_CNT_W'(1));
                    digits_next    = {digits_reg[BCD_W-5:0], 4'd0};
                    left_next      = left_reg - DIG_CNT_W'(1);
                    if (left_reg == DIG_CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        digits_reg   <= digits_next;
        left_reg     <= left_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CHAR_W){1'b0}}, out_char_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ sv/sbda_checker.sv @@
// Port-level checks for the converter, bound to the top level.
module sbda_checker
    import sbda_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // Every character is a minus sign or a decimal digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata == OUT_DATA_W'(CHAR_MINUS)) ||
            ((m_axis_tdata >= OUT_DATA_W'(CHAR_ZERO)) &&
             (m_axis_tdata <= OUT_DATA_W'(CHAR_ZERO) + OUT_DATA_W'(9))))
        else $error("character outside minus and digits");

    // A minus sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata == OUT_DATA_W'(CHAR_MINUS)) |-> !m_axis_tlast)
        else $error("minus sign marked last");

    // Accepting an item closes the input while it is converted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after accept");

    // A stalled character holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output changed");

endmodule

bind signed_binary_to_decimal_ascii_top sbda_checker u_sbda_checker (.*);
